// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/pac_pkg.sv =====
`timescale 1ns / 1ps

package pac_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_TINT_COLOR = 3'd1;
   localparam logic [2:0] REG_TINT_ALPHA = 3'd2;
   localparam logic [2:0] REG_FILL_COLOR = 3'd3;
   localparam logic [2:0] REG_FILL_ALPHA = 3'd4;

   // modes
   localparam logic [1:0] MODE_BLEND = 2'd0;
   localparam logic [1:0] MODE_FILL  = 2'd1;
   localparam logic [1:0] MODE_TFILL = 2'd2;

   // per-pixel operation decided in the first stage
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_BLEND = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;
   localparam logic [1:0] OP_TFILL = 2'd3;

   localparam logic [8:0]  ONE_FACTOR   = 9'd256;
   localparam logic [16:0] ALPHA_ONE    = 17'h10000;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

   localparam logic [1:0]  RST_MODE       = 2'd0;
   localparam logic [26:0] RST_TINT_COLOR = 27'h4020100;
   localparam logic [8:0]  RST_TINT_ALPHA = 9'd256;
   localparam logic [23:0] RST_FILL_COLOR = 24'h000000;
   localparam logic [8:0]  RST_FILL_ALPHA = 9'd256;

   typedef struct packed {
      logic [1:0]       mode;
      logic [2:0][8:0]  tint;        // saturated, index 0 = blue
      logic [8:0]       tint_alpha;  // saturated
      logic [2:0][7:0]  fill;
      logic [8:0]       fill_alpha;  // raw
   } cfg_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [16:0]      alpha;
      logic [2:0][15:0] st;
      logic [2:0][7:0]  dst;
      logic [2:0][15:0] fp;
      logic [2:0][15:0] dp;
   } s1_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [2:0][31:0] p;
      logic [2:0][23:0] q;
      logic [2:0][7:0]  bf;
   } s2_type;

   function automatic logic [8:0] sat_factor(input logic [8:0] v);
      return (v > ONE_FACTOR) ? ONE_FACTOR : v;
   endfunction

endpackage

// ===== hw/rtl/pixel_alpha_compositor_core.sv =====
`timescale 1ns / 1ps
// A pixel transferred on req_ passes through the stage 1, stage 2 and stage 3 registers
// before its result is ready to transfer on rsp_.
// Throughput: one pixel per cycle; three register stages (products, weighted
// products, final sum) fill bubbles while rsp_ready is low and stall only when full.
// Reset: synchronous active high; clears stage valid bits and loads register
// defaults (blend mode, unit tints, black fill, opaque fill alpha).
module pixel_alpha_compositor_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_src_pixel,
   input  logic [31:0]                    req_dst_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_out_pixel,
   output logic                           rsp_write_enable,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   pac_pkg::cfg_type cfg;
   pac_pkg::s1_type  s1_data;
   pac_pkg::s2_type  s2_data;
   logic             s1_valid;
   logic             s1_ready;
   logic             s2_valid;
   logic             s2_ready;

   pac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pac_stage1 u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .src_pixel (req_src_pixel),
      .dst_pixel (req_dst_pixel),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   pac_stage2 u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   pac_stage3 u_stage3 (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid),
      .in_ready     (s2_ready),
      .in_data      (s2_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_pixel    (rsp_out_pixel),
      .write_enable (rsp_write_enable)
   );

endmodule

// ===== hw/rtl/pac_csr.sv =====
`timescale 1ns / 1ps

module pac_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pac_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pac_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pac_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output pac_pkg::cfg_type               cfg
);

   logic [1:0]  mode_ff;
   logic [26:0] tint_color_ff;
   logic [8:0]  tint_alpha_ff;
   logic [23:0] fill_color_ff;
   logic [8:0]  fill_alpha_ff;
   logic [2:0]  index;
   logic        wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= pac_pkg::RST_MODE;
         tint_color_ff <= pac_pkg::RST_TINT_COLOR;
         tint_alpha_ff <= pac_pkg::RST_TINT_ALPHA;
         fill_color_ff <= pac_pkg::RST_FILL_COLOR;
         fill_alpha_ff <= pac_pkg::RST_FILL_ALPHA;
      end else if (wr_en) begin
         unique case (index)
            pac_pkg::REG_MODE:       mode_ff       <= pwdata[1:0];
            pac_pkg::REG_TINT_COLOR: tint_color_ff <= pwdata[26:0];
            pac_pkg::REG_TINT_ALPHA: tint_alpha_ff <= pwdata[8:0];
            pac_pkg::REG_FILL_COLOR: fill_color_ff <= pwdata[23:0];
            pac_pkg::REG_FILL_ALPHA: fill_alpha_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pac_pkg::REG_MODE:       prdata = {30'd0, mode_ff};
         pac_pkg::REG_TINT_COLOR: prdata = {5'd0, tint_color_ff};
         pac_pkg::REG_TINT_ALPHA: prdata = {23'd0, tint_alpha_ff};
         pac_pkg::REG_FILL_COLOR: prdata = {8'd0, fill_color_ff};
         pac_pkg::REG_FILL_ALPHA: prdata = {23'd0, fill_alpha_ff};
         default:                 prdata = '0;
      endcase
   end

   always_comb begin
      cfg.mode       = mode_ff;
      cfg.tint[0]    = pac_pkg::sat_factor(tint_color_ff[8:0]);
      cfg.tint[1]    = pac_pkg::sat_factor(tint_color_ff[17:9]);
      cfg.tint[2]    = pac_pkg::sat_factor(tint_color_ff[26:18]);
      cfg.tint_alpha = pac_pkg::sat_factor(tint_alpha_ff);
      cfg.fill       = fill_color_ff;
      cfg.fill_alpha = fill_alpha_ff;
   end

endmodule

// ===== hw/rtl/pac_stage1.sv =====
`timescale 1ns / 1ps

// Operation decode and first products.
module pac_stage1 (
   input  logic             clock,
   input  logic             reset,
   input  pac_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      src_pixel,
   input  logic [31:0]      dst_pixel,
   output logic             out_valid,
   input  logic             out_ready,
   output pac_pkg::s1_type  out_data
);

   logic            valid_ff;
   pac_pkg::s1_type data_ff;
   pac_pkg::s1_type data_in;
   logic [7:0]      sa;
   logic [8:0]      eff_alpha;
   logic [8:0]      eff_inv;
   logic [3:0][7:0] src_ch;
   logic [3:0][7:0] dst_ch;
   logic [16:0]     alpha_full;
   logic [16:0]     st_full;
   logic [16:0]     fp_full;
   logic [16:0]     dp_full;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      src_ch = src_pixel;
      dst_ch = dst_pixel;
      sa     = src_ch[3];

      if (cfg.mode == pac_pkg::MODE_BLEND) begin
         data_in.op = (sa != 8'd0) ? pac_pkg::OP_BLEND : pac_pkg::OP_NONE;
      end else if (cfg.mode == pac_pkg::MODE_FILL ||
                   (cfg.mode == pac_pkg::MODE_TFILL &&
                    cfg.fill_alpha >= pac_pkg::ONE_FACTOR)) begin
         data_in.op = pac_pkg::OP_FILL;
      end else if (cfg.mode == pac_pkg::MODE_TFILL && cfg.fill_alpha != 9'd0) begin
         data_in.op = pac_pkg::OP_TFILL;
      end else begin
         data_in.op = pac_pkg::OP_NONE;
      end

      // opaque fill runs through the translucent path at full opacity
      eff_alpha = (data_in.op == pac_pkg::OP_FILL) ? pac_pkg::ONE_FACTOR
                                                    : {1'b0, cfg.fill_alpha[7:0]};
      eff_inv   = pac_pkg::ONE_FACTOR - eff_alpha;

      alpha_full    = 17'(sa) * 17'(cfg.tint_alpha);
      data_in.alpha = alpha_full;

      for (int k = 0; k < 3; k++) begin
         st_full         = 17'(src_ch[k]) * 17'(cfg.tint[k]);
         fp_full         = 17'(cfg.fill[k]) * 17'(eff_alpha);
         dp_full         = 17'(dst_ch[k]) * 17'(eff_inv);
         data_in.st[k]   = st_full[15:0];
         data_in.fp[k]   = fp_full[15:0];
         data_in.dp[k]   = dp_full[15:0];
         data_in.dst[k]  = dst_ch[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/pac_stage2.sv =====
`timescale 1ns / 1ps

// Blend weights applied; translucent fill finished.
module pac_stage2 (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  pac_pkg::s1_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output pac_pkg::s2_type out_data
);

   logic            valid_ff;
   pac_pkg::s2_type data_ff;
   pac_pkg::s2_type data_in;
   logic [16:0]     inv_alpha;
   logic [32:0]     p_full;
   logic [24:0]     q_full;
   logic [16:0]     f_sum;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.op = in_data.op;
      inv_alpha  = pac_pkg::ALPHA_ONE - in_data.alpha;
      for (int k = 0; k < 3; k++) begin
         // s*t*a stays below 2^32
         p_full        = 33'(in_data.st[k]) * 33'(in_data.alpha);
         q_full        = 25'(in_data.dst[k]) * 25'(inv_alpha);
         f_sum         = 17'(in_data.fp[k]) + 17'(in_data.dp[k]);
         data_in.p[k]  = p_full[31:0];
         data_in.q[k]  = q_full[23:0];
         data_in.bf[k] = f_sum[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/pac_stage3.sv =====
`timescale 1ns / 1ps

// Final sum, result select and output register.
module pac_stage3 (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  pac_pkg::s2_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [31:0]     out_pixel,
   output logic            write_enable
);

   logic        valid_ff;
   logic [31:0] pixel_ff;
   logic [31:0] pixel_in;
   logic        we_ff;
   logic        we_in;
   logic [2:0][7:0] blend_ch;
   logic [31:0] sum;

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign out_pixel    = pixel_ff;
   assign write_enable = we_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum         = in_data.p[k] + {in_data.q[k], 8'h00};
         blend_ch[k] = sum[31:24];
      end
      case (in_data.op) inside
         pac_pkg::OP_BLEND: begin
            pixel_in = {pac_pkg::ALPHA_OPAQUE, blend_ch};
            we_in    = 1'b1;
         end
         pac_pkg::OP_FILL, pac_pkg::OP_TFILL: begin
            pixel_in = {pac_pkg::ALPHA_OPAQUE, in_data.bf};
            we_in    = 1'b1;
         end
         default: begin
            pixel_in = '0;
            we_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
         we_ff    <= we_in;
      end
   end

endmodule

// ===== hw/rtl/pac_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pac_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_pixel,
   input logic        rsp_write_enable
);

   logic        no_write_zero;
   logic        opaque_alpha;
   logic        stalled;
   logic        held_result;
   logic [31:0] last_pixel_ff;
   logic        last_we_ff;

   // previous cycle's result, for the hold check
   always_ff @(posedge clock) begin
      last_pixel_ff <= rsp_out_pixel;
      last_we_ff    <= rsp_write_enable;
   end

   assign no_write_zero = rsp_out_pixel == 32'd0;
   assign opaque_alpha  = rsp_out_pixel[31:24] == pac_pkg::ALPHA_OPAQUE;
   assign stalled       = rsp_valid && !rsp_ready;
   assign held_result   = rsp_valid && (rsp_out_pixel == last_pixel_ff) &&
                          (rsp_write_enable == last_we_ff);

   // a skipped write carries an all-zero pixel
   `ASSERT_IMPLY(a_skip_zero, clock, reset, rsp_valid && !rsp_write_enable, no_write_zero)
   // every written pixel is opaque
   `ASSERT_IMPLY(a_write_opaque, clock, reset, rsp_valid && rsp_write_enable, opaque_alpha)
   // a stalled result holds
   `ASSERT_NEXT(a_stall_hold, clock, reset, stalled, held_result)
   // pipeline empties on reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind pixel_alpha_compositor_core pac_checker u_pac_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_pixel    (rsp_out_pixel),
   .rsp_write_enable (rsp_write_enable)
);

// ===== tb/pixel_compositor_checker.sv =====
`timescale 1ns / 1ps

module pixel_compositor_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [31:0]                    req_src_pixel,
   input  logic [31:0]                    req_dst_pixel,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [31:0]                    rsp_out_pixel,
   input  logic                           rsp_write_enable,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [pac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             mismatches,
   output int                             pending
);
   import pac_pkg::*;

   typedef struct packed {
      logic [31:0] pixel;
      logic        wr;
   } pixel_result_type;

   pixel_result_type expected_pixels [$];

   // shadow of the register file, kept from observed writes
   logic [1:0]  cfg_mode;
   logic [26:0] cfg_tint;
   logic [8:0]  cfg_tint_alpha;
   logic [23:0] cfg_fill;
   logic [8:0]  cfg_fill_alpha;

   // any factor with bit 8 set is at or above one
   function automatic logic [8:0] unit_clamp(input logic [8:0] f);
      if (f[8]) begin
         return ONE_FACTOR;
      end
      return f;
   endfunction

   function automatic pixel_result_type composite(input logic [31:0] src,
                                                  input logic [31:0] dst);
      pixel_result_type r;
      logic [63:0]      sa, ta, a, ia, t, s, d, v;
      int               k;
      r.pixel = '0;
      r.wr    = 1'b0;
      case (cfg_mode)
         MODE_BLEND: begin
            if (src[31:24] != 8'h00) begin
               sa = 64'(src[31:24]);
               ta = 64'(unit_clamp(cfg_tint_alpha));
               a  = sa * ta;
               ia = 64'(ALPHA_ONE);
               ia = ia - a;
               r.pixel[31:24] = ALPHA_OPAQUE;
               for (k = 0; k < 3; k++) begin
                  t = 64'(unit_clamp(cfg_tint[9*k +: 9]));
                  s = 64'(src[8*k +: 8]);
                  d = 64'(dst[8*k +: 8]);
                  v = (s * t * a + d * ia * 64'd256) >> 24;
                  r.pixel[8*k +: 8] = v[7:0];
               end
               r.wr = 1'b1;
            end
         end
         MODE_FILL: begin
            r.pixel = {ALPHA_OPAQUE, cfg_fill};
            r.wr    = 1'b1;
         end
         MODE_TFILL: begin
            if (cfg_fill_alpha >= ONE_FACTOR) begin
               r.pixel = {ALPHA_OPAQUE, cfg_fill};
               r.wr    = 1'b1;
            end else if (cfg_fill_alpha != 9'd0) begin
               a  = 64'(cfg_fill_alpha);
               ia = 64'(ONE_FACTOR);
               ia = ia - a;
               r.pixel[31:24] = ALPHA_OPAQUE;
               for (k = 0; k < 3; k++) begin
                  s = 64'(cfg_fill[8*k +: 8]);
                  d = 64'(dst[8*k +: 8]);
                  v = (s * a + d * ia) >> 8;
                  r.pixel[8*k +: 8] = v[7:0];
               end
               r.wr = 1'b1;
            end
         end
         default: begin
            // unused mode never writes
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         expected_pixels.delete();
         mismatches     <= 0;
         pending        <= 0;
         cfg_mode       <= RST_MODE;
         cfg_tint       <= RST_TINT_COLOR;
         cfg_tint_alpha <= RST_TINT_ALPHA;
         cfg_fill       <= RST_FILL_COLOR;
         cfg_fill_alpha <= RST_FILL_ALPHA;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result transfer with nothing expected: out_pixel %h write_enable %b",
                      rsp_out_pixel, rsp_write_enable);
               errs++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_pixel !== want.pixel) begin
                  $error("out_pixel mismatch: expected %h, actual %h",
                         want.pixel, rsp_out_pixel);
                  errs++;
               end
               if (rsp_write_enable !== want.wr) begin
                  $error("write_enable mismatch: expected %b, actual %b",
                         want.wr, rsp_write_enable);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(composite(req_src_pixel, req_dst_pixel));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MODE:       cfg_mode       <= csr_pwdata[1:0];
               REG_TINT_COLOR: cfg_tint       <= csr_pwdata[26:0];
               REG_TINT_ALPHA: cfg_tint_alpha <= csr_pwdata[8:0];
               REG_FILL_COLOR: cfg_fill       <= csr_pwdata[23:0];
               REG_FILL_ALPHA: cfg_fill_alpha <= csr_pwdata[8:0];
               default: begin
               end
            endcase
         end
         mismatches <= mismatches + errs;
         pending    <= expected_pixels.size();
      end
   end

endmodule

// ===== tb/pixel_alpha_compositor_core_tb.sv =====
`timescale 1ns / 1ps

module pixel_alpha_compositor_core_tb;
   import pac_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PIXELS_PER_PHASE = 36;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_src_pixel = '0;
   logic [31:0]           req_dst_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_out_pixel;
   logic                  rsp_write_enable;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  mismatches;
   int  pending;
   int  pixels_sent = 0;
   int  settings_applied = 0;
   int  idle_cycles = 0;
   logic no_idle = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pixel_alpha_compositor_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_pixel    (req_src_pixel),
      .req_dst_pixel    (req_dst_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_write_enable (rsp_write_enable),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   pixel_compositor_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_pixel    (req_src_pixel),
      .req_dst_pixel    (req_dst_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_write_enable (rsp_write_enable),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 33);
      end
   end

   // cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
      if (!no_idle) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_src_pixel <= src;
      req_dst_pixel <= dst;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // hold off until every outstanding pixel has come back; the first edge lets
   // the count take in a transfer made at the edge just passed
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // optionally fill the bits above the register width with junk
   function automatic logic [31:0] widen(input logic [31:0] field, input int width,
                                         input bit wide);
      logic [31:0] junk;
      junk = $urandom;
      return wide ? (field | (junk << width)) : field;
   endfunction

   task automatic apply_setting(input logic [1:0] mode, input logic [26:0] tint,
                                input logic [8:0] tint_alpha, input logic [23:0] fill,
                                input logic [8:0] fill_alpha, input bit wide);
      drain();
      csr_write(REG_MODE,       widen(32'(mode), 2, wide));
      csr_write(REG_TINT_COLOR, widen(32'(tint), 27, wide));
      csr_write(REG_TINT_ALPHA, widen(32'(tint_alpha), 9, wide));
      csr_write(REG_FILL_COLOR, widen(32'(fill), 24, wide));
      csr_write(REG_FILL_ALPHA, widen(32'(fill_alpha), 9, wide));
      settings_applied++;
   endtask

   function automatic logic [8:0] pick_factor();
      case ($urandom_range(7))
         0:       return 9'd0;
         1, 2:    return ONE_FACTOR;
         3:       return 9'($urandom_range(511, 257));
         default: return 9'($urandom_range(255, 1));
      endcase
   endfunction

   function automatic logic [8:0] pick_fill_alpha();
      case ($urandom_range(7))
         0:       return 9'd0;
         1:       return ONE_FACTOR;
         2:       return 9'($urandom_range(511, 257));
         default: return 9'($urandom_range(255, 1));
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 40) return MODE_BLEND;
      if (r < 55) return MODE_FILL;
      if (r < 90) return MODE_TFILL;
      return MODE_UNUSED;
   endfunction

   function automatic logic [31:0] random_src();
      logic [31:0] body;
      logic [7:0]  alpha;
      body = $urandom;
      case ($urandom_range(9))
         0:       alpha = 8'h00;
         1:       alpha = 8'hff;
         default: alpha = body[31:24];
      endcase
      return {alpha, body[23:0]};
   endfunction

   initial begin
      int p;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain source-over, zero source alpha first
      send_pixel(32'h00ffffff, 32'h12345678);
      send_pixel(32'hffffffff, 32'h00000000);
      send_pixel(32'hff000000, 32'hffffffff);
      send_pixel(32'h80a5c35a, 32'h7f5a3ca5);

      // tint factors above one saturate
      apply_setting(MODE_BLEND, 27'h7ffffff, 9'h1ff, 24'h000000, ONE_FACTOR, 1'b0);
      send_pixel(32'hffffffff, 32'h00000000);
      send_pixel(32'h40aa55cc, 32'hff336699);

      // zero tint alpha writes the destination back
      apply_setting(MODE_BLEND, 27'h0000000, 9'd0, 24'h000000, ONE_FACTOR, 1'b0);
      send_pixel(32'h01ffffff, 32'hffabcdef);
      send_pixel(32'hff000000, 32'h00ffffff);

      apply_setting(MODE_FILL, 27'h4020100, ONE_FACTOR, 24'hffffff, 9'd0, 1'b0);
      send_pixel(32'h00000000, 32'h00000000);
      send_pixel(32'hffffffff, 32'h12345678);

      // translucent fill: none, opaque, above opaque, mid, edges
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'hff8000, 9'd0, 1'b0);
      send_pixel(32'hffffffff, 32'hffffffff);
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'hff8000, ONE_FACTOR, 1'b0);
      send_pixel(32'h00000000, 32'h00123456);
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'h13579b, 9'h1ff, 1'b0);
      send_pixel(32'h00000000, 32'hffffffff);
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'hffffff, 9'd128, 1'b0);
      send_pixel(32'h00000000, 32'h00000000);
      send_pixel(32'h12345678, 32'hffffffff);
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'hffffff, 9'd1, 1'b0);
      send_pixel(32'h00000000, 32'h00808080);
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'h0000ff, 9'd255, 1'b0);
      send_pixel(32'h00000000, 32'hffffff00);

      apply_setting(MODE_UNUSED, 27'h4020100, ONE_FACTOR, 24'hffffff, ONE_FACTOR, 1'b0);
      send_pixel(32'hffffffff, 32'hffffffff);
      send_pixel(32'h80808080, 32'h00000000);

      // junk above the register widths must be dropped
      apply_setting(MODE_TFILL, 27'h4020100, ONE_FACTOR, 24'ha5a55a, 9'd77, 1'b1);
      send_pixel(32'hffffffff, 32'h5a5aa5a5);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         apply_setting(pick_mode(), {pick_factor(), pick_factor(), pick_factor()},
                       pick_factor(), 24'($urandom), pick_fill_alpha(),
                       $urandom_range(1) == 1);
         no_idle <= (p == 5);
         for (n = 0; n < PIXELS_PER_PHASE; n++) begin
            send_pixel(random_src(), $urandom);
            if ($urandom_range(39) == 0) begin
               drain();
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("%0d pixels over %0d register settings: blend, opaque fill, translucent fill",
               pixels_sent, settings_applied + 1);
      $display("and the unused mode, with saturated tints and junk in wide register writes");
      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
